// File: hdl/qvr_pkg.sv
`timescale 1ns / 1ps
package qvr_pkg;
    localparam int QW = 16;
    localparam int VW = 32;
    localparam int MW = 34;   // matrix terms
    localparam int NW = 33;   // squared norm
    localparam int PW = 66;   // product
    localparam int SW = 68;   // sum of three products
    localparam int DIVW = 67; // magnitude bits divided
    localparam int IN_BYTES = 20;
    localparam int OUT_BYTES = 13;

    typedef struct packed {
        logic signed [QW-1:0] qw;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic signed [VW-1:0] vz;
    } t_in;

    typedef struct packed {
        logic signed [VW-1:0] rx;
        logic signed [VW-1:0] ry;
        logic signed [VW-1:0] rz;
        logic                 sat;
        logic                 zq;
    } t_out;
endpackage

// File: hdl/qvr_matrix.sv
`timescale 1ns / 1ps
module qvr_matrix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  qvr_pkg::t_in                  i_item,
    output logic                          o_valid,
    output logic signed [qvr_pkg::SW-1:0] o_sum [3],
    output logic [qvr_pkg::NW-1:0]        o_norm
);
    // stage 1: products of quaternion components
    logic                               r_v1;
    logic signed [31:0]                 r_p [10];
    logic signed [qvr_pkg::VW-1:0]      r_vec1 [3];
    // stage 2: matrix terms
    logic                               r_v2;
    logic signed [qvr_pkg::MW-1:0]      r_m [9];
    logic [qvr_pkg::NW-1:0]             r_n2;
    logic signed [qvr_pkg::VW-1:0]      r_vec2 [3];
    // stage 3: matrix by vector products
    logic                               r_v3;
    logic signed [qvr_pkg::PW-1:0]      r_pr [9];
    logic [qvr_pkg::NW-1:0]             r_n3;
    // stage 4: row sums
    logic                               r_v4;
    logic signed [qvr_pkg::SW-1:0]      r_s [3];
    logic [qvr_pkg::NW-1:0]             r_n4;

    logic signed [31:0]            w_qw, w_qx, w_qy, w_qz;
    logic signed [qvr_pkg::MW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    logic signed [qvr_pkg::MW-1:0] n_m [9];

    always_comb begin
        w_qw = 32'(i_item.qw); w_qx = 32'(i_item.qx);
        w_qy = 32'(i_item.qy); w_qz = 32'(i_item.qz);
    end

    always_comb begin
        ww = qvr_pkg::MW'(r_p[0]); xx = qvr_pkg::MW'(r_p[1]);
        yy = qvr_pkg::MW'(r_p[2]); zz = qvr_pkg::MW'(r_p[3]);
        xy = qvr_pkg::MW'(r_p[4]); wz = qvr_pkg::MW'(r_p[5]);
        xz = qvr_pkg::MW'(r_p[6]); wy = qvr_pkg::MW'(r_p[7]);
        yz = qvr_pkg::MW'(r_p[8]); wx = qvr_pkg::MW'(r_p[9]);
        n_m[0] = ww + xx - yy - zz;
        n_m[1] = (xy - wz) <<< 1;
        n_m[2] = (xz + wy) <<< 1;
        n_m[3] = (xy + wz) <<< 1;
        n_m[4] = ww - xx + yy - zz;
        n_m[5] = (yz - wx) <<< 1;
        n_m[6] = (xz - wy) <<< 1;
        n_m[7] = (yz + wx) <<< 1;
        n_m[8] = ww - xx - yy + zz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= w_qw * w_qw;
            r_p[1] <= w_qx * w_qx;
            r_p[2] <= w_qy * w_qy;
            r_p[3] <= w_qz * w_qz;
            r_p[4] <= w_qx * w_qy;
            r_p[5] <= w_qw * w_qz;
            r_p[6] <= w_qx * w_qz;
            r_p[7] <= w_qw * w_qy;
            r_p[8] <= w_qy * w_qz;
            r_p[9] <= w_qw * w_qx;
            r_vec1[0] <= i_item.vx; r_vec1[1] <= i_item.vy; r_vec1[2] <= i_item.vz;
            r_m   <= n_m;
            r_n2  <= qvr_pkg::NW'(ww + xx + yy + zz);
            r_vec2 <= r_vec1;
            for (int i = 0; i < 9; i++) begin
                r_pr[i] <= qvr_pkg::PW'(r_m[i]) * qvr_pkg::PW'(r_vec2[i % 3]);
            end
            r_n3 <= r_n2;
            for (int r = 0; r < 3; r++) begin
                r_s[r] <= qvr_pkg::SW'(r_pr[3*r]) + qvr_pkg::SW'(r_pr[3*r+1])
                        + qvr_pkg::SW'(r_pr[3*r+2]);
            end
            r_n4 <= r_n3;
        end
    end

    assign o_valid = r_v4;
    assign o_sum   = r_s;
    assign o_norm  = r_n4;
endmodule

// File: hdl/qvr_divider.sv
`timescale 1ns / 1ps
module qvr_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [qvr_pkg::SW-1:0] i_sum [3],
    input  logic [qvr_pkg::NW-1:0]        i_norm,
    output logic                          o_valid,
    output qvr_pkg::t_out                 o_item
);
    localparam int D = qvr_pkg::DIVW;
    localparam int RW = qvr_pkg::NW + 1;

    // one restoring step per stage, three lanes side by side
    logic                   r_v   [D+1];
    logic [D-1:0]           r_q   [D+1][3];
    logic [RW-1:0]          r_rem [D+1][3];
    logic                   r_neg [D+1][3];
    logic [qvr_pkg::NW-1:0] r_n   [D+1];

    logic [RW-1:0] n_tr [D][3];
    logic [RW-1:0] n_df [D][3];

    always_comb begin
        for (int s = 0; s < D; s++) begin
            for (int l = 0; l < 3; l++) begin
                n_tr[s][l] = {r_rem[s][l][RW-2:0], r_q[s][l][D-1]};
                n_df[s][l] = n_tr[s][l] - RW'(r_n[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= D; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < D; s++) r_v[s+1] <= r_v[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= i_norm;
            for (int l = 0; l < 3; l++) begin
                r_neg[0][l] <= i_sum[l][qvr_pkg::SW-1];
                r_q[0][l]   <= i_sum[l][qvr_pkg::SW-1] ? D'(-i_sum[l]) : D'(i_sum[l]);
                r_rem[0][l] <= '0;
            end
            for (int s = 0; s < D; s++) begin
                r_n[s+1] <= r_n[s];
                for (int l = 0; l < 3; l++) begin
                    r_neg[s+1][l] <= r_neg[s][l];
                    if (!n_df[s][l][RW-1]) begin
                        r_rem[s+1][l] <= n_df[s][l];
                        r_q[s+1][l]   <= {r_q[s][l][D-2:0], 1'b1};
                    end else begin
                        r_rem[s+1][l] <= n_tr[s][l];
                        r_q[s+1][l]   <= {r_q[s][l][D-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // rounding and saturation
    logic                      r_vo;
    qvr_pkg::t_out             r_o;
    qvr_pkg::t_out             n_o;
    logic [D:0]                n_rq [3];
    logic [qvr_pkg::VW-1:0]    n_c  [3];
    logic                      n_sat [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_rq[l] = {1'b0, r_q[D][l]} +
                      (D+1)'(({r_rem[D][l], 1'b0}) >= (RW+1)'(r_n[D]));
            if (!r_neg[D][l]) begin
                n_sat[l] = n_rq[l] > (D+1)'(32'h7FFF_FFFF);
                n_c[l] = n_sat[l] ? 32'h7FFF_FFFF : n_rq[l][31:0];
            end else begin
                n_sat[l] = n_rq[l] > (D+1)'(33'h0_8000_0000);
                n_c[l] = n_sat[l] ? 32'h8000_0000 : (~n_rq[l][31:0] + 32'd1);
            end
        end
        n_o.zq  = (r_n[D] == '0);
        n_o.rx  = n_o.zq ? '0 : n_c[0];
        n_o.ry  = n_o.zq ? '0 : n_c[1];
        n_o.rz  = n_o.zq ? '0 : n_c[2];
        n_o.sat = !n_o.zq && (n_sat[0] || n_sat[1] || n_sat[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[D];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_o <= n_o;
    end

    assign o_valid = r_vo;
    assign o_item  = r_o;

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_o.zq |-> !r_o.sat && r_o.rx == '0) else $error("zero quat output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_en) && $past(i_rst_n) |-> $stable(r_vo)) else $error("stall moved");
    a_sat_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_o.sat |-> !r_o.zq) else $error("sat with zero");
endmodule

// File: hdl/quaternion_vector_rotate_top.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit first)
// s_axis  | in  | quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z (160 bits)
// m_axis  | out | rot_x, rot_y, rot_z, saturated, zero_quat (98 bits, padded to 104)
// One item per cycle while the output is not stalled; the path is 4 product stages, one divider
// load stage, 67 divide steps, then round/saturate into the output register.
// The divide chain sets the latency: one quotient bit per stage.
// Reset is synchronous, active low, and clears all valid bits.
// A stall freezes the whole pipeline; nothing is lost or repeated.
module quaternion_vector_rotate_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [qvr_pkg::IN_BYTES*8-1:0]    s_axis_tdata,  // qw,qx,qy,qz,vx,vy,vz
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [qvr_pkg::OUT_BYTES*8-1:0]   m_axis_tdata   // rx,ry,rz,sat,zq
);
    qvr_pkg::t_in                  w_in;
    logic                          w_en, w_mv, w_dv;
    logic signed [qvr_pkg::SW-1:0] w_sum [3];
    logic [qvr_pkg::NW-1:0]        w_norm;
    qvr_pkg::t_out                 w_out;

    assign w_in.qw = s_axis_tdata[15:0];
    assign w_in.qx = s_axis_tdata[31:16];
    assign w_in.qy = s_axis_tdata[47:32];
    assign w_in.qz = s_axis_tdata[63:48];
    assign w_in.vx = s_axis_tdata[95:64];
    assign w_in.vy = s_axis_tdata[127:96];
    assign w_in.vz = s_axis_tdata[159:128];

    assign w_en = m_axis_tready || !w_dv;
    assign s_axis_tready = w_en;

    qvr_matrix u_mat (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_axis_tvalid), .i_item(w_in),
        .o_valid(w_mv), .o_sum(w_sum), .o_norm(w_norm)
    );

    qvr_divider u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_mv), .i_sum(w_sum),
        .i_norm(w_norm), .o_valid(w_dv), .o_item(w_out)
    );

    assign m_axis_tvalid = w_dv;
    assign m_axis_tdata  = {6'd0, w_out.zq, w_out.sat, w_out.rz, w_out.ry, w_out.rx};
endmodule

// File: test/tb_quaternion_vector_rotate_top.sv
`timescale 1ns / 1ps
module tb_quaternion_vector_rotate_top;
    localparam int LATENCY    = 73;
    localparam int N_RANDOM   = 1250;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic signed [qvr_pkg::QW-1:0] qw, qx, qy, qz;
        logic signed [qvr_pkg::VW-1:0] vx, vy, vz;
    } t_quat_vec;

    typedef struct packed {
        logic signed [qvr_pkg::VW-1:0] rx;
        logic signed [qvr_pkg::VW-1:0] ry;
        logic signed [qvr_pkg::VW-1:0] rz;
        logic                          sat;
        logic                          zq;
    } t_rot;

    typedef struct {
        t_quat_vec item;
        bit        typed;
        t_rot      want;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [qvr_pkg::IN_BYTES*8-1:0] s_axis_tdata;   // qw,qx,qy,qz,vx,vy,vz
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [qvr_pkg::OUT_BYTES*8-1:0] m_axis_tdata;  // rx,ry,rz,sat,zq

    t_rot  rot_expected[$];
    int    n_sent, n_got, n_err, n_sat, n_zero, idle_cycles;
    bit    stim_done, hold_rx;
    t_row  rows[$];

    quaternion_vector_rotate_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // round(sum/n) ties away from zero, clipped to 32 bits
    function automatic logic signed [qvr_pkg::VW-1:0] rot_component(
            input logic signed [69:0] m0, m1, m2,
            input logic signed [69:0] v0, v1, v2,
            input logic [69:0] n, inout logic sat);
        logic signed [69:0] acc;
        logic [69:0] mag, quo, rem;
        logic neg;
        acc = m0 * v0 + m1 * v1 + m2 * v2;
        neg = acc < 0;
        mag = neg ? -acc : acc;
        quo = mag / n;
        rem = mag % n;
        if (2 * rem >= n) quo = quo + 1;
        if (!neg && quo > 70'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (neg && quo > 70'h8000_0000) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return neg ? -quo[31:0] : quo[31:0];
    endfunction

    function automatic t_rot rotate_vector(input t_quat_vec it);
        logic signed [69:0] w, x, y, z, ww, xx, yy, zz, vx, vy, vz;
        logic [69:0] n;
        t_rot r;
        w = 70'(it.qw); x = 70'(it.qx); y = 70'(it.qy); z = 70'(it.qz);
        vx = 70'(it.vx); vy = 70'(it.vy); vz = 70'(it.vz);
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        n = ww + xx + yy + zz;
        r = '{default: '0};
        if (n == 0) begin
            r.zq = 1'b1;
            return r;
        end
        r.rx = rot_component(ww + xx - yy - zz, 2 * (x * y - w * z), 2 * (x * z + w * y),
                             vx, vy, vz, n, r.sat);
        r.ry = rot_component(2 * (x * y + w * z), ww - xx + yy - zz, 2 * (y * z - w * x),
                             vx, vy, vz, n, r.sat);
        r.rz = rot_component(2 * (x * z - w * y), 2 * (y * z + w * x), ww - xx - yy + zz,
                             vx, vy, vz, n, r.sat);
        return r;
    endfunction

    function automatic t_quat_vec random_item();
        t_quat_vec it;
        int k;
        k = $urandom_range(0, 9);
        it.qw = qvr_pkg::QW'($urandom); it.qx = qvr_pkg::QW'($urandom);
        it.qy = qvr_pkg::QW'($urandom); it.qz = qvr_pkg::QW'($urandom);
        it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
        if (k < 4) begin
            // unit-ish quaternion, modest vector
            it.qw = qvr_pkg::QW'($signed($urandom_range(0, 32767)) - 16384);
            it.qx = qvr_pkg::QW'($signed($urandom_range(0, 32767)) - 16384);
            it.qy = qvr_pkg::QW'($signed($urandom_range(0, 32767)) - 16384);
            it.qz = qvr_pkg::QW'($signed($urandom_range(0, 32767)) - 16384);
            it.vx = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            it.vy = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            it.vz = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        end else if (k == 4) begin
            it.qw = qvr_pkg::QW'($signed($urandom_range(0, 6)) - 3);
            it.qx = qvr_pkg::QW'($signed($urandom_range(0, 2)) - 1);
            it.qy = qvr_pkg::QW'($signed($urandom_range(0, 2)) - 1);
            it.qz = qvr_pkg::QW'($signed($urandom_range(0, 2)) - 1);
        end else if (k == 5) begin
            it.qx = '0; it.qy = '0; it.qz = '0;
            if ($urandom_range(0, 1)) it.qw = '0;
        end
        return it;
    endfunction

    function automatic t_row mk_row(input int w, x, y, z, a, b, c,
                                    input bit typed, input t_rot want);
        t_row r;
        r.item.qw = qvr_pkg::QW'(w);
        r.item.qx = qvr_pkg::QW'(x);
        r.item.qy = qvr_pkg::QW'(y);
        r.item.qz = qvr_pkg::QW'(z);
        r.item.vx = a;
        r.item.vy = b;
        r.item.vz = c;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    task automatic send_item(input t_quat_vec it, input bit typed, input t_rot want);
        s_axis_tdata <= {it.vz, it.vy, it.vx, it.qz, it.qy, it.qx, it.qw};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        rot_expected.push_back(typed ? want : rotate_vector(it));
        n_sent++;
    endtask

    task automatic sender_gap();
        int g;
        g = $urandom_range(0, 9);
        if (g < 5) return;
        s_axis_tvalid <= 1'b0;
        repeat (g < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge i_clk);
    endtask

    initial begin
        t_rot z0;
        t_rot zq1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        hold_rx = 1'b0;
        z0 = '{default: '0};
        zq1 = z0; zq1.zq = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(mk_row(0, 0, 0, 0, 123, -5, 7, 1, zq1));
        rows.push_back(mk_row(0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1, zq1));
        rows.push_back(mk_row(16384, 0, 0, 0, 65536, -65536, 3, 1,
                              '{32'sd65536, -32'sd65536, 32'sd3, 1'b0, 1'b0}));
        rows.push_back(mk_row(-32768, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1,
                              '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b0, 1'b0}));
        rows.push_back(mk_row(0, 1, 0, 0, 0, 0, 0, 1, z0));
        rows.push_back(mk_row(32767, 32767, 32767, 32767, 32'sh7FFF_FFFF,
                              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, z0));
        rows.push_back(mk_row(-32768, -32768, -32768, -32768, 32'sh8000_0000,
                              32'sh8000_0000, 32'sh8000_0000, 0, z0));
        rows.push_back(mk_row(11585, 0, 0, 11585, 65536, 0, 0, 0, z0));
        rows.push_back(mk_row(0, 16384, 0, 0, 1, 2, 3, 0, z0));
        rows.push_back(mk_row(1, 1, 0, 0, 1, 1, 1, 0, z0));
        rows.push_back(mk_row(1, 1, 1, 0, 1, 1, 1, 0, z0));
        rows.push_back(mk_row(3, 0, 0, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5, 0, z0));
        rows.push_back(mk_row(0, 0, 32767, -32768, 32'sh8000_0000, 32'sh7FFF_FFFF, 9, 0, z0));
        rows.push_back(mk_row(-1, 2, -3, 4, -100, 200, -300, 0, z0));
        foreach (rows[i]) begin
            send_item(rows[i].item, rows[i].typed, rows[i].want);
            sender_gap();
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) begin
                s_axis_tvalid <= 1'b0;
                while (rot_expected.size() != 0) @(posedge i_clk);
            end
            if (i == 600) hold_rx <= 1'b1;
            if (i >= 500 && i < 700) send_item(random_item(), 0, z0);
            else begin
                send_item(random_item(), 0, z0);
                sender_gap();
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // long receiver hold-off while sender keeps pushing
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end else begin
                int g;
                g = $urandom_range(0, 19);
                if (g < 12) m_axis_tready <= 1'b1;
                else begin
                    m_axis_tready <= 1'b0;
                    repeat (g < 19 ? $urandom_range(0, 3) : $urandom_range(10, 60))
                        @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_rot got, want;
            got.rx = m_axis_tdata[31:0];
            got.ry = m_axis_tdata[63:32];
            got.rz = m_axis_tdata[95:64];
            got.sat = m_axis_tdata[96];
            got.zq = m_axis_tdata[97];
            n_got++;
            if (rot_expected.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected item %p", got);
            end else begin
                want = rot_expected.pop_front();
                n_sat += want.sat;
                n_zero += want.zq;
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch item %0d: exp %p got %p", n_got - 1, want, got);
                end
            end
        end
    end

    initial begin
        n_sent = 0; n_got = 0; n_err = 0; n_sat = 0; n_zero = 0;
        idle_cycles = 0; stim_done = 1'b0;
        fork
            begin
                wait (stim_done && rot_expected.size() == 0);
                repeat (LATENCY + 20) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
            end
        join_any
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress, %0d results outstanding", rot_expected.size());
            $display("[FAIL] regression broken");
        end else begin
            $display("rotated %0d items, %0d clipped, %0d zero quaternions",
                     n_got, n_sat, n_zero);
            if (n_err == 0 && rot_expected.size() == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
